### sv/x86_16bit_instruction_decoder_unit_assert.svh
// Assertion macros for the decoder unit.
`ifndef X86_16BIT_INSTRUCTION_DECODER_UNIT_ASSERT_SVH
`define X86_16BIT_INSTRUCTION_DECODER_UNIT_ASSERT_SVH
`define X86D_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define X86D_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

### sv/x86d_pkg.sv
// ---------------------------------------------------------------------------
// x86d_pkg
// Types and constants for the 8086 instruction decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package x86d_pkg;
    localparam int CODE_W = 56;
    localparam int ADDR_W = 16;
    localparam logic [ADDR_W-1:0] RESET_ADDR = 16'h0100;
    localparam logic [6:0] MN_MOV = 7'd0;
    localparam logic [6:0] MN_PUSH = 7'd1;
    localparam logic [6:0] MN_POP = 7'd2;
    localparam logic [6:0] MN_XCHG = 7'd3;
    localparam logic [6:0] MN_INC = 7'd16;
    localparam logic [6:0] MN_DEC = 7'd21;
    localparam logic [6:0] MN_TEST = 7'd43;
    localparam logic [6:0] MN_REP = 7'd46;
    localparam logic [6:0] MN_CALL = 7'd52;
    localparam logic [6:0] MN_JMP = 7'd53;
    localparam logic [6:0] MN_INT = 7'd76;
    localparam logic [6:0] MN_ESC = 7'd88;
    localparam logic [1:0] PFX_NONE = 2'd0;
    localparam logic [1:0] PFX_REP = 2'd1;
    localparam logic [1:0] PFX_REPNZ = 2'd2;

    typedef struct packed {
        logic        known;
        logic [2:0]  length;
        logic [6:0]  mnemonic;
        logic [1:0]  prefix_kind;
        logic        far_form;
        logic        width_bit;
        logic        direction_bit;
        logic [7:0]  modrm_byte;
        logic signed [15:0] displacement;
        logic [15:0] immediate;
        logic [15:0] target;
    } t_result;

    typedef logic [7:0] t_ops8 [8];
    localparam t_ops8 ALU_OPS = '{8'd14, 8'd44, 8'd15, 8'd20, 8'd42, 8'd19, 8'd45, 8'd23};
    localparam t_ops8 UNARY_OPS = '{8'd43, 8'd43, 8'd34, 8'd22, 8'd26, 8'd27, 8'd29, 8'd30};
    localparam t_ops8 SHIFT_OPS = '{8'd38, 8'd39, 8'd40, 8'd41, 8'd35, 8'd36, 8'd35, 8'd37};
    localparam t_ops8 INCDEC_OPS = '{8'd16, 8'd21, 8'd52, 8'd52, 8'd53, 8'd53, 8'd1, 8'd21};
    typedef logic [7:0] t_ops16 [16];
    localparam t_ops16 JCC_OPS = '{8'd62, 8'd70, 8'd59, 8'd67, 8'd56, 8'd64, 8'd60, 8'd68,
                                   8'd63, 8'd71, 8'd61, 8'd69, 8'd57, 8'd65, 8'd58, 8'd66};

    function automatic logic is_known(input logic [7:0] op);
        is_known = !(op == 8'h26 || op == 8'h2E || op == 8'h36 || op == 8'h3E ||
                     op[7:4] == 4'h6 || op == 8'hC0 || op == 8'hC1 || op == 8'hC8 ||
                     op == 8'hC9 || op == 8'hD6 || op == 8'hF1);
    endfunction
endpackage

### sv/x86d_if.sv
// ---------------------------------------------------------------------------
// x86d_if
// Valid/ready channel carrying one payload.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
interface x86d_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/x86d_core.sv
// ---------------------------------------------------------------------------
// x86d_core
// Combinational decode of one instruction from a window of code bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module x86d_core #(
    parameter int WINDOW_BYTES = 7
) (
    input  logic [x86d_pkg::CODE_W-1:0] i_window,
    input  logic [x86d_pkg::ADDR_W-1:0] i_addr,
    output x86d_pkg::t_result           o_res
);
    import x86d_pkg::*;

    logic [7:0] b [8];
    logic [7:0] op0, op1, op, rb, m;
    logic       pre, use1;
    logic [2:0] p, reg_f, n, mlen, lenp;
    logic [1:0] mo;
    logic       has_rel, rel_w, mr, imm_on, imm_w, w, dv;
    logic [2:0] ip;
    logic [15:0] rel, disp_m;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            b[k] = (k < WINDOW_BYTES) ? i_window[(k%7)*8 +: 8] : 8'h00;
            if (k >= 7) b[k] = 8'h00;
        end
    end

    always_comb begin
        o_res = '0;
        op0 = b[0];
        op1 = b[1];
        pre = is_known(op0) && (op0 == 8'hF2 || op0 == 8'hF3);
        use1 = pre && is_known(op1) && op1 != 8'hF2 && op1 != 8'hF3;
        p = use1 ? 3'd1 : 3'd0;
        op = use1 ? op1 : op0;
        rb = use1 ? b[2] : b[1];
        reg_f = rb[5:3];
        w = op[0];
        dv = op[1];
        mr = 1'b0;
        imm_on = 1'b0;
        imm_w = 1'b0;
        has_rel = 1'b0;
        rel_w = 1'b0;
        n = 3'd1;
        rel = '0;
        lenp = 3'd1;
        // ModRM field decode, valid when mr is set.
        m = rb;
        mo = m[7:6];
        ip = p + 3'd2;
        if ((mo == 2'd0 && m[2:0] == 3'd6) || mo == 2'd2) begin
            mlen = 3'd3;
            disp_m = {b[ip + 3'd1], b[ip]};
        end else if (mo == 2'd1) begin
            mlen = 3'd2;
            disp_m = {{8{b[ip][7]}}, b[ip]};
        end else begin
            mlen = 3'd1;
            disp_m = '0;
        end
        if (!is_known(op0)) begin
            o_res.length = 3'd1;
        end else begin
            o_res.known = 1'b1;
            o_res.prefix_kind = !pre ? PFX_NONE : (op0 == 8'hF3) ? PFX_REP : PFX_REPNZ;
            if (op < 8'h40) begin
                if (op[2:0] < 3'd4) begin
                    o_res.mnemonic = ALU_OPS[op[5:3]][6:0];
                    o_res.width_bit = w; o_res.direction_bit = dv; mr = 1'b1;
                end else if (op[2:0] < 3'd6) begin
                    o_res.mnemonic = ALU_OPS[op[5:3]][6:0];
                    o_res.width_bit = w; imm_on = 1'b1; imm_w = w;
                end else if (op[2:0] == 3'd6) begin
                    o_res.mnemonic = MN_PUSH;
                end else if (op < 8'h20) begin
                    o_res.mnemonic = MN_POP;
                end else begin
                    o_res.mnemonic = (op == 8'h27) ? 7'd18 : (op == 8'h2F) ? 7'd25 :
                                     (op == 8'h37) ? 7'd17 : 7'd24;
                end
            end else if (op < 8'h60) begin
                case (op[4:3])
                    2'd0: o_res.mnemonic = MN_INC;
                    2'd1: o_res.mnemonic = MN_DEC;
                    2'd2: o_res.mnemonic = MN_PUSH;
                    default: o_res.mnemonic = MN_POP;
                endcase
            end else if (op[7:4] == 4'h7) begin
                o_res.mnemonic = JCC_OPS[op[3:0]][6:0]; has_rel = 1'b1;
            end else if (op <= 8'h83) begin
                o_res.mnemonic = ALU_OPS[reg_f][6:0];
                o_res.width_bit = w; o_res.direction_bit = dv;
                mr = 1'b1; imm_on = 1'b1; imm_w = w && !dv;
            end else if (op <= 8'h8B) begin
                o_res.mnemonic = (op < 8'h86) ? MN_TEST : (op < 8'h88) ? MN_XCHG : MN_MOV;
                o_res.width_bit = w; mr = 1'b1;
                if (op >= 8'h88) o_res.direction_bit = dv;
            end else if (op <= 8'h8F) begin
                o_res.mnemonic = (op == 8'h8D) ? 7'd7 : (op == 8'h8F) ? MN_POP : MN_MOV;
                o_res.width_bit = 1'b1; mr = 1'b1;
            end else if (op < 8'h98) begin
                o_res.mnemonic = MN_XCHG;
            end else if (op >= 8'hA0 && op <= 8'hA3) begin
                o_res.mnemonic = MN_MOV; o_res.width_bit = w;
                o_res.displacement = {b[p + 3'd2], b[p + 3'd1]};
                n = 3'd3;
            end else if (op >= 8'hA4 && op <= 8'hAF) begin
                case (op[3:1])
                    3'd2: o_res.mnemonic = 7'd47;
                    3'd3: o_res.mnemonic = 7'd48;
                    3'd4: o_res.mnemonic = 7'd43;
                    3'd5: o_res.mnemonic = 7'd51;
                    3'd6: o_res.mnemonic = 7'd50;
                    default: o_res.mnemonic = 7'd49;
                endcase
                o_res.width_bit = w;
                if (op == 8'hA8 || op == 8'hA9) begin
                    imm_on = 1'b1; imm_w = w;
                end
            end else if (op[7:4] == 4'hB) begin
                o_res.mnemonic = MN_MOV; o_res.width_bit = op[3];
                imm_on = 1'b1; imm_w = op[3];
            end else if (op >= 8'hD0 && op <= 8'hD3) begin
                o_res.mnemonic = SHIFT_OPS[reg_f][6:0];
                o_res.width_bit = w; o_res.direction_bit = dv; mr = 1'b1;
            end else if (op >= 8'hD8 && op <= 8'hDF) begin
                o_res.mnemonic = MN_ESC; o_res.width_bit = 1'b1; mr = 1'b1;
            end else if (op >= 8'hE0 && op <= 8'hE3) begin
                case (op[1:0])
                    2'd0: o_res.mnemonic = 7'd74;
                    2'd1: o_res.mnemonic = 7'd73;
                    2'd2: o_res.mnemonic = 7'd72;
                    default: o_res.mnemonic = 7'd75;
                endcase
                has_rel = 1'b1;
            end else if (op >= 8'hE4 && op <= 8'hE7) begin
                o_res.mnemonic = (op < 8'hE6) ? 7'd4 : 7'd5;
                o_res.width_bit = w; imm_on = 1'b1;
            end else if (op >= 8'hEC && op <= 8'hEF) begin
                o_res.mnemonic = (op < 8'hEE) ? 7'd4 : 7'd5; o_res.width_bit = w;
            end else if (op == 8'hF6 || op == 8'hF7) begin
                o_res.mnemonic = UNARY_OPS[reg_f][6:0]; o_res.width_bit = w; mr = 1'b1;
                if (reg_f == 3'd0) begin
                    imm_on = 1'b1; imm_w = w;
                end
            end else if (op == 8'hFE || op == 8'hFF) begin
                o_res.mnemonic = (reg_f == 3'd7 && op == 8'hFF) ? MN_JMP :
                                 INCDEC_OPS[reg_f][6:0];
                o_res.width_bit = w; mr = 1'b1;
                o_res.far_form = (reg_f == 3'd3 || reg_f == 3'd5);
            end else begin
                case (op)
                    8'h98: o_res.mnemonic = 7'd32;
                    8'h99: o_res.mnemonic = 7'd33;
                    8'h9A, 8'hEA: begin
                        o_res.mnemonic = (op == 8'h9A) ? MN_CALL : MN_JMP;
                        o_res.far_form = 1'b1;
                        o_res.immediate = {b[p + 3'd2], b[p + 3'd1]};
                        o_res.target = {b[p + 3'd4], b[p + 3'd3]};
                        n = 3'd5;
                    end
                    8'h9B: o_res.mnemonic = 7'd87;
                    8'h9C: o_res.mnemonic = 7'd12;
                    8'h9D: o_res.mnemonic = 7'd13;
                    8'h9E: o_res.mnemonic = 7'd11;
                    8'h9F: o_res.mnemonic = 7'd10;
                    8'hC2: begin o_res.mnemonic = 7'd54; imm_on = 1'b1; imm_w = 1'b1; end
                    8'hC3: o_res.mnemonic = 7'd54;
                    8'hC4: begin o_res.mnemonic = 7'd9; o_res.width_bit = 1'b1; mr = 1'b1; end
                    8'hC5: begin o_res.mnemonic = 7'd8; o_res.width_bit = 1'b1; mr = 1'b1; end
                    8'hC6, 8'hC7: begin
                        o_res.mnemonic = MN_MOV; o_res.width_bit = w; mr = 1'b1;
                        imm_on = 1'b1; imm_w = w;
                    end
                    8'hCA: begin o_res.mnemonic = 7'd55; imm_on = 1'b1; imm_w = 1'b1; end
                    8'hCB: o_res.mnemonic = 7'd55;
                    8'hCC: begin o_res.mnemonic = MN_INT; o_res.immediate = 16'd3; end
                    8'hCD: begin o_res.mnemonic = MN_INT; imm_on = 1'b1; end
                    8'hCE: o_res.mnemonic = 7'd77;
                    8'hCF: o_res.mnemonic = 7'd78;
                    8'hD4: begin o_res.mnemonic = 7'd28; imm_on = 1'b1; end
                    8'hD5: begin o_res.mnemonic = 7'd31; imm_on = 1'b1; end
                    8'hD7: o_res.mnemonic = 7'd19;
                    8'hE8: begin o_res.mnemonic = MN_CALL; has_rel = 1'b1; rel_w = 1'b1; end
                    8'hE9: begin o_res.mnemonic = MN_JMP; has_rel = 1'b1; rel_w = 1'b1; end
                    8'hEB: begin o_res.mnemonic = MN_JMP; has_rel = 1'b1; end
                    8'hF0: o_res.mnemonic = 7'd89;
                    8'hF4: o_res.mnemonic = 7'd86;
                    8'hF5: o_res.mnemonic = 7'd80;
                    8'hF8: o_res.mnemonic = 7'd79;
                    8'hF9: o_res.mnemonic = 7'd81;
                    8'hFA: o_res.mnemonic = 7'd84;
                    8'hFB: o_res.mnemonic = 7'd85;
                    8'hFC: o_res.mnemonic = 7'd82;
                    8'hFD: o_res.mnemonic = 7'd83;
                    default: begin
                        o_res.mnemonic = MN_REP; o_res.direction_bit = op[0];
                    end
                endcase
            end
            if (mr) begin
                o_res.modrm_byte = m;
                o_res.displacement = disp_m;
                n = 3'd1 + mlen;
            end
            if (imm_on) begin
                o_res.immediate = imm_w ? {b[p + n + 3'd1], b[p + n]} : {8'h00, b[p + n]};
                n = n + (imm_w ? 3'd2 : 3'd1);
            end
            if (has_rel) begin
                rel = rel_w ? {b[p + 3'd2], b[p + 3'd1]} : {{8{b[p + 3'd1][7]}}, b[p + 3'd1]};
                n = rel_w ? 3'd3 : 3'd2;
            end else begin
                rel = '0;
            end
            lenp = p + n;
            o_res.length = lenp;
            if (has_rel) o_res.target = i_addr + 16'(lenp) + rel;
        end
    end
endmodule

### sv/x86_16bit_instruction_decoder_unit.sv
// ---------------------------------------------------------------------------
// x86_16bit_instruction_decoder_unit
// Decodes one 8086 instruction per request and tracks the code address.
// ---------------------------------------------------------------------------
// Each accepted request is decoded in the cycle it is taken and its result is
// registered, so one instruction per clock is sustained while the response side
// is ready; the only chain from one request to the next is the address add
// through the running address. Results appear in the cycle after acceptance.
// Writing the start address reloads the running address.
`timescale 1ns / 1ps
`include "x86_16bit_instruction_decoder_unit_assert.svh"
module x86_16bit_instruction_decoder_unit #(
    parameter int WINDOW_BYTES = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [x86d_pkg::ADDR_W-1:0]  i_cfg_wdata,
    x86d_if.sink                         i_req,
    x86d_if.source                       o_rsp
);
    import x86d_pkg::*;

    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_valid;
    t_result           r_res, w_res;
    logic              acc;

    x86d_core #(.WINDOW_BYTES(WINDOW_BYTES)) u_core (
        .i_window (i_req.data[CODE_W-1:0]),
        .i_addr   (r_addr),
        .o_res    (w_res)
    );

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign acc = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_valid;
    assign o_rsp.data = r_res;

    always_comb begin
        n_addr = r_addr;
        if (i_cfg_we) begin
            n_addr = i_cfg_wdata;
        end else if (acc) begin
            n_addr = r_addr + 16'(w_res.length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= RESET_ADDR;
            r_valid <= 1'b0;
        end else begin
            r_addr <= n_addr;
            if (acc) begin
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
        if (acc) begin
            r_res <= w_res;
        end
    end

    `X86D_ASSERT_NEXT(a_addr_adv, i_clk, i_rst_n, acc && !i_cfg_we,
        r_addr == $past(r_addr) + 16'($past(w_res.length)), "address did not advance")
    `X86D_ASSERT_NEXT(a_valid_set, i_clk, i_rst_n, acc, r_valid, "result lost")
    `X86D_ASSERT_IMPL(a_len_ok, i_clk, i_rst_n, r_valid |-> r_res.length != 3'd0,
        "zero length")
endmodule

### verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives code windows into the 8086 decoder under several idle and stall
// patterns. Typed rows are checked against fixed results, the others against
// a behavioral decode of the same window that tracks its own running address.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
    import x86d_pkg::*;

    localparam int RSP_W = $bits(t_result);
    localparam int HALF_NS = 6;
    localparam int N_PER_PHASE = 350;

    localparam logic [6:0] MN_IN = 7'd4, MN_OUT = 7'd5, MN_LEA = 7'd7, MN_LDS = 7'd8;
    localparam logic [6:0] MN_LES = 7'd9, MN_LAHF = 7'd10, MN_SAHF = 7'd11;
    localparam logic [6:0] MN_PUSHF = 7'd12, MN_POPF = 7'd13, MN_AAA = 7'd17;
    localparam logic [6:0] MN_DAA = 7'd18, MN_XLAT = 7'd19, MN_AAS = 7'd24;
    localparam logic [6:0] MN_DAS = 7'd25, MN_AAM = 7'd28, MN_AAD = 7'd31;
    localparam logic [6:0] MN_CBW = 7'd32, MN_CWD = 7'd33, MN_RET = 7'd54;
    localparam logic [6:0] MN_RETF = 7'd55, MN_INTO = 7'd77, MN_IRET = 7'd78;
    localparam logic [6:0] MN_CLC = 7'd79, MN_CMC = 7'd80, MN_STC = 7'd81;
    localparam logic [6:0] MN_CLD = 7'd82, MN_STD = 7'd83, MN_CLI = 7'd84;
    localparam logic [6:0] MN_STI = 7'd85, MN_HLT = 7'd86, MN_WAIT = 7'd87;
    localparam logic [6:0] MN_LOCK = 7'd89;
    localparam logic [7:0] OP_REPNZ = 8'hF2, OP_REP = 8'hF3;

    localparam logic [6:0] ALU_MN [8] = '{14, 44, 15, 20, 42, 19, 45, 23};
    localparam logic [6:0] UNARY_MN [8] = '{43, 43, 34, 22, 26, 27, 29, 30};
    localparam logic [6:0] SHIFT_MN [8] = '{38, 39, 40, 41, 35, 36, 35, 37};
    localparam logic [6:0] INCDEC_MN [8] = '{16, 21, 52, 52, 53, 53, 1, 21};
    localparam logic [6:0] JCC_MN [16] = '{62, 70, 59, 67, 56, 64, 60, 68,
                                          63, 71, 61, 69, 57, 65, 58, 66};
    localparam logic [6:0] ROW_MN [4] = '{16, 21, 1, 2};
    localparam logic [6:0] STR_MN [6] = '{47, 48, 43, 51, 50, 49};
    localparam logic [6:0] LOOP_MN [4] = '{74, 73, 72, 75};

    typedef struct {
        logic [55:0] window;
        logic        typed;
        t_result     want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [ADDR_W-1:0] i_cfg_wdata = '0;

    x86d_if #(.W(CODE_W)) req_if ();
    x86d_if #(.W(RSP_W)) rsp_if ();

    x86_16bit_instruction_decoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source)
    );

    always #(HALF_NS) i_clk = ~i_clk;

    t_result expected_decodes [$];
    logic [15:0] pc_model;
    int mismatches = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    function automatic logic [7:0] code_byte(input logic [55:0] w, input int i);
        if (i >= 7) return 8'h00;
        return w[8*i +: 8];
    endfunction

    function automatic logic [15:0] code_word(input logic [55:0] w, input int i);
        return {code_byte(w, i + 1), code_byte(w, i)};
    endfunction

    function automatic logic opcode_defined(input logic [7:0] op);
        if (op == 8'h26 || op == 8'h2E || op == 8'h36 || op == 8'h3E) return 1'b0;
        if (op >= 8'h60 && op <= 8'h6F) return 1'b0;
        if (op == 8'hC0 || op == 8'hC1 || op == 8'hC8 || op == 8'hC9) return 1'b0;
        if (op == 8'hD6 || op == 8'hF1) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int take_modrm(input logic [55:0] w, input int at, inout t_result r);
        logic [7:0] m;
        logic [7:0] b;
        m = code_byte(w, at);
        b = code_byte(w, at + 1);
        r.modrm_byte = m;
        if ((m[7:6] == 2'd0 && m[2:0] == 3'd6) || m[7:6] == 2'd2) begin
            r.displacement = code_word(w, at + 1);
            return 3;
        end
        if (m[7:6] == 2'd1) begin
            r.displacement = {{8{b[7]}}, b};
            return 2;
        end
        return 1;
    endfunction

    function automatic int take_imm(input logic [55:0] w, input int at, input logic wide,
                                    inout t_result r);
        if (wide) begin
            r.immediate = code_word(w, at);
            return 2;
        end
        r.immediate = {8'h00, code_byte(w, at)};
        return 1;
    endfunction

    function automatic int take_rel(input logic [55:0] w, input int at, input logic wide,
                                    inout logic has_rel, inout logic [15:0] rel);
        logic [7:0] b;
        b = code_byte(w, at);
        has_rel = 1'b1;
        if (wide) begin
            rel = code_word(w, at);
            return 2;
        end
        rel = {{8{b[7]}}, b};
        return 1;
    endfunction

    function automatic int decode_opcode(input logic [55:0] w, input int p, inout t_result r,
                                         inout logic has_rel, inout logic [15:0] rel);
        logic [7:0] op;
        logic [7:0] m1;
        logic [2:0] rf;
        int n;
        op = code_byte(w, p);
        m1 = code_byte(w, p + 1);
        rf = m1[5:3];
        if (op < 8'h40) begin
            if (op[2:0] < 3'd4) begin
                r.mnemonic = ALU_MN[op[5:3]];
                r.width_bit = op[0];
                r.direction_bit = op[1];
                return 1 + take_modrm(w, p + 1, r);
            end
            if (op[2:0] < 3'd6) begin
                r.mnemonic = ALU_MN[op[5:3]];
                r.width_bit = op[0];
                return 1 + take_imm(w, p + 1, op[0], r);
            end
            if (op[2:0] == 3'd6) begin
                r.mnemonic = MN_PUSH;
                return 1;
            end
            if (op < 8'h20) begin
                r.mnemonic = MN_POP;
                return 1;
            end
            r.mnemonic = (op == 8'h27) ? MN_DAA : (op == 8'h2F) ? MN_DAS :
                         (op == 8'h37) ? MN_AAA : MN_AAS;
            return 1;
        end
        if (op < 8'h60) begin
            r.mnemonic = ROW_MN[op[4:3]];
            return 1;
        end
        if (op >= 8'h70 && op < 8'h80) begin
            r.mnemonic = JCC_MN[op[3:0]];
            return 1 + take_rel(w, p + 1, 1'b0, has_rel, rel);
        end
        if (op <= 8'h83) begin
            r.mnemonic = ALU_MN[rf];
            r.width_bit = op[0];
            r.direction_bit = op[1];
            n = 1 + take_modrm(w, p + 1, r);
            return n + take_imm(w, p + n, op[0] && !op[1], r);
        end
        if (op <= 8'h8B) begin
            r.mnemonic = (op < 8'h86) ? MN_TEST : (op < 8'h88) ? MN_XCHG : MN_MOV;
            r.width_bit = op[0];
            if (op >= 8'h88) r.direction_bit = op[1];
            return 1 + take_modrm(w, p + 1, r);
        end
        if (op <= 8'h8F) begin
            r.mnemonic = (op == 8'h8D) ? MN_LEA : (op == 8'h8F) ? MN_POP : MN_MOV;
            r.width_bit = 1'b1;
            return 1 + take_modrm(w, p + 1, r);
        end
        if (op < 8'h98) begin
            r.mnemonic = MN_XCHG;
            return 1;
        end
        if (op >= 8'hA0 && op <= 8'hA3) begin
            r.mnemonic = MN_MOV;
            r.width_bit = op[0];
            r.displacement = code_word(w, p + 1);
            return 3;
        end
        if (op >= 8'hA4 && op <= 8'hAF) begin
            r.mnemonic = STR_MN[3'((op - 8'hA4) >> 1)];
            r.width_bit = op[0];
            if (op == 8'hA8 || op == 8'hA9) return 1 + take_imm(w, p + 1, op[0], r);
            return 1;
        end
        if (op >= 8'hB0 && op <= 8'hBF) begin
            r.mnemonic = MN_MOV;
            r.width_bit = op[3];
            return 1 + take_imm(w, p + 1, op[3], r);
        end
        if (op >= 8'hD0 && op <= 8'hD3) begin
            r.mnemonic = SHIFT_MN[rf];
            r.width_bit = op[0];
            r.direction_bit = op[1];
            return 1 + take_modrm(w, p + 1, r);
        end
        if (op >= 8'hD8 && op <= 8'hDF) begin
            r.mnemonic = MN_ESC;
            r.width_bit = 1'b1;
            return 1 + take_modrm(w, p + 1, r);
        end
        if (op >= 8'hE0 && op <= 8'hE3) begin
            r.mnemonic = LOOP_MN[op[1:0]];
            return 1 + take_rel(w, p + 1, 1'b0, has_rel, rel);
        end
        if (op >= 8'hE4 && op <= 8'hE7) begin
            r.mnemonic = (op < 8'hE6) ? MN_IN : MN_OUT;
            r.width_bit = op[0];
            return 1 + take_imm(w, p + 1, 1'b0, r);
        end
        if (op >= 8'hEC && op <= 8'hEF) begin
            r.mnemonic = (op < 8'hEE) ? MN_IN : MN_OUT;
            r.width_bit = op[0];
            return 1;
        end
        if (op == 8'hF6 || op == 8'hF7) begin
            r.mnemonic = UNARY_MN[rf];
            r.width_bit = op[0];
            n = 1 + take_modrm(w, p + 1, r);
            if (rf == 3'd0) n += take_imm(w, p + n, op[0], r);
            return n;
        end
        if (op == 8'hFE || op == 8'hFF) begin
            r.mnemonic = (rf == 3'd7 && op == 8'hFF) ? MN_JMP : INCDEC_MN[rf];
            r.width_bit = op[0];
            r.far_form = (rf == 3'd3 || rf == 3'd5);
            return 1 + take_modrm(w, p + 1, r);
        end
        case (op)
            8'h98: begin r.mnemonic = MN_CBW; return 1; end
            8'h99: begin r.mnemonic = MN_CWD; return 1; end
            8'h9A, 8'hEA: begin
                r.mnemonic = (op == 8'h9A) ? MN_CALL : MN_JMP;
                r.far_form = 1'b1;
                r.immediate = code_word(w, p + 1);
                r.target = code_word(w, p + 3);
                return 5;
            end
            8'h9B: begin r.mnemonic = MN_WAIT; return 1; end
            8'h9C: begin r.mnemonic = MN_PUSHF; return 1; end
            8'h9D: begin r.mnemonic = MN_POPF; return 1; end
            8'h9E: begin r.mnemonic = MN_SAHF; return 1; end
            8'h9F: begin r.mnemonic = MN_LAHF; return 1; end
            8'hC2: begin r.mnemonic = MN_RET; return 1 + take_imm(w, p + 1, 1'b1, r); end
            8'hC3: begin r.mnemonic = MN_RET; return 1; end
            8'hC4, 8'hC5: begin
                r.mnemonic = (op == 8'hC4) ? MN_LES : MN_LDS;
                r.width_bit = 1'b1;
                return 1 + take_modrm(w, p + 1, r);
            end
            8'hC6, 8'hC7: begin
                r.mnemonic = MN_MOV;
                r.width_bit = op[0];
                n = 1 + take_modrm(w, p + 1, r);
                return n + take_imm(w, p + n, op[0], r);
            end
            8'hCA: begin r.mnemonic = MN_RETF; return 1 + take_imm(w, p + 1, 1'b1, r); end
            8'hCB: begin r.mnemonic = MN_RETF; return 1; end
            8'hCC: begin r.mnemonic = MN_INT; r.immediate = 16'd3; return 1; end
            8'hCD: begin r.mnemonic = MN_INT; return 1 + take_imm(w, p + 1, 1'b0, r); end
            8'hCE: begin r.mnemonic = MN_INTO; return 1; end
            8'hCF: begin r.mnemonic = MN_IRET; return 1; end
            8'hD4: begin r.mnemonic = MN_AAM; return 1 + take_imm(w, p + 1, 1'b0, r); end
            8'hD5: begin r.mnemonic = MN_AAD; return 1 + take_imm(w, p + 1, 1'b0, r); end
            8'hD7: begin r.mnemonic = MN_XLAT; return 1; end
            8'hE8: begin r.mnemonic = MN_CALL; return 1 + take_rel(w, p + 1, 1'b1, has_rel, rel); end
            8'hE9: begin r.mnemonic = MN_JMP; return 1 + take_rel(w, p + 1, 1'b1, has_rel, rel); end
            8'hEB: begin r.mnemonic = MN_JMP; return 1 + take_rel(w, p + 1, 1'b0, has_rel, rel); end
            8'hF0: begin r.mnemonic = MN_LOCK; return 1; end
            8'hF4: begin r.mnemonic = MN_HLT; return 1; end
            8'hF5: begin r.mnemonic = MN_CMC; return 1; end
            8'hF8: begin r.mnemonic = MN_CLC; return 1; end
            8'hF9: begin r.mnemonic = MN_STC; return 1; end
            8'hFA: begin r.mnemonic = MN_CLI; return 1; end
            8'hFB: begin r.mnemonic = MN_STI; return 1; end
            8'hFC: begin r.mnemonic = MN_CLD; return 1; end
            8'hFD: begin r.mnemonic = MN_STD; return 1; end
            default: ;
        endcase
        r.mnemonic = MN_REP;
        r.direction_bit = op[0];
        return 1;
    endfunction

    function automatic t_result decode_instruction(input logic [55:0] w, input logic [15:0] pc);
        t_result r;
        logic has_rel;
        logic [15:0] rel;
        logic [7:0] op0;
        logic [7:0] op1;
        int n;
        r = '0;
        has_rel = 1'b0;
        rel = '0;
        op0 = code_byte(w, 0);
        op1 = code_byte(w, 1);
        n = 1;
        if (opcode_defined(op0)) begin
            r.known = 1'b1;
            if (op0 == OP_REPNZ || op0 == OP_REP) begin
                r.prefix_kind = (op0 == OP_REP) ? PFX_REP : PFX_REPNZ;
                if (opcode_defined(op1) && op1 != OP_REPNZ && op1 != OP_REP)
                    n = 1 + decode_opcode(w, 1, r, has_rel, rel);
                else
                    n = decode_opcode(w, 0, r, has_rel, rel);
            end else begin
                n = decode_opcode(w, 0, r, has_rel, rel);
            end
        end
        r.length = n[2:0];
        if (has_rel) r.target = pc + 16'(n) + rel;
        return r;
    endfunction

    function automatic logic [55:0] random_window();
        logic [55:0] w;
        w = 56'({$urandom, $urandom});
        if ($urandom_range(99) < 12) w[7:0] = $urandom_range(1) ? OP_REP : OP_REPNZ;
        return w;
    endfunction

    task automatic send_window(input logic [55:0] w, input logic typed, input t_result want);
        t_result exp_r;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= w;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        exp_r = decode_instruction(w, pc_model);
        expected_decodes.insert(expected_decodes.size(), typed ? want : exp_r);
        pc_model = pc_model + 16'(exp_r.length);
        @(negedge i_clk);
    endtask

    task automatic drain_and_write(input logic [15:0] addr);
        int guard;
        req_if.valid <= 1'b0;
        guard = 0;
        while (expected_decodes.size() != 0 && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= addr;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        pc_model = addr;
    endtask

    always @(negedge i_clk) begin
        rsp_if.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = t_result'(rsp_if.data);
            if (expected_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected response: %p", got);
            end else begin
                want = expected_decodes.pop_front();
                if (got.known !== want.known || got.length !== want.length ||
                    got.mnemonic !== want.mnemonic || got.prefix_kind !== want.prefix_kind ||
                    got.far_form !== want.far_form || got.width_bit !== want.width_bit ||
                    got.direction_bit !== want.direction_bit ||
                    got.modrm_byte !== want.modrm_byte ||
                    got.displacement !== want.displacement ||
                    got.immediate !== want.immediate || got.target !== want.target) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial begin
        #(2_000_000 * 2 * HALF_NS);
        $display("** x86_16bit_instruction_decoder_unit: FAILED **");
        $finish;
    end

    initial begin
        t_row rows [$];
        t_result none;
        int guard;
        none = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        pc_model = RESET_ADDR;
        rows = '{
            '{56'h0000_0000_00FE_EB, 1'b1, '{known: 1'b1, length: 3'd2, mnemonic: MN_JMP,
                target: 16'h0100, default: '0}},
            '{56'h0000_0000_0000_26, 1'b1, '{known: 1'b0, length: 3'd1, default: '0}},
            '{56'h0000_0000_0000_CC, 1'b1, '{known: 1'b1, length: 3'd1, mnemonic: MN_INT,
                immediate: 16'd3, default: '0}},
            '{56'h0000_5678_1234_EA, 1'b1, '{known: 1'b1, length: 3'd5, mnemonic: MN_JMP,
                far_form: 1'b1, immediate: 16'h1234, target: 16'h5678, default: '0}},
            '{56'h0000_0000_0000_00, 1'b0, none},
            '{56'hFF_FFFF_FFFF_FFFF, 1'b0, none},
            '{56'h0000_0000_00A4_F3, 1'b0, none},
            '{56'h0000_0000_00F2_F2, 1'b0, none},
            '{56'h0000_0000_0026_F3, 1'b0, none},
            '{56'h0000_0000_80EB_F3, 1'b0, none},
            '{56'h0000_0000_007F_70, 1'b0, none},
            '{56'h0000_0000_FFFF_E8, 1'b0, none},
            '{56'h0000_0012_34C0_81, 1'b0, none},
            '{56'h0000_0080_45C0_83, 1'b0, none},
            '{56'h0000_7F34_1206_80, 1'b0, none},
            '{56'h00BE_EF80_0086_81, 1'b0, none},
            '{56'hBEEF_8000_8681_F3, 1'b0, none},
            '{56'h0000_0000_00F8_FF, 1'b0, none},
            '{56'h0000_0000_00F8_FE, 1'b0, none},
            '{56'h0000_0000_55C8_F6, 1'b0, none},
            '{56'h0000_0000_00F0_D0, 1'b0, none},
            '{56'h0000_0000_80D0_FE, 1'b0, none},
            '{56'h0000_0000_1234_A1, 1'b0, none},
            '{56'h0000_0000_0A21_D4, 1'b0, none},
            '{56'h0000_0000_FE46_D8, 1'b0, none}
        };
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (rows[i]) send_window(rows[i].window, rows[i].typed, rows[i].want);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin drain_and_write(16'hFFFF); idle_pct = 0; stall_pct = 0; end
                1: begin drain_and_write(16'h0000); idle_pct = 74; stall_pct = 0; end
                2: begin drain_and_write(16'($urandom)); idle_pct = 0; stall_pct = 74; end
                default: begin drain_and_write(16'hFFF8); idle_pct = 29; stall_pct = 29; end
            endcase
            for (int k = 0; k < N_PER_PHASE; k++) send_window(random_window(), 1'b0, none);
        end
        req_if.valid <= 1'b0;
        guard = 0;
        while (expected_decodes.size() != 0 && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (4) @(negedge i_clk);
        if (mismatches == 0 && expected_decodes.size() == 0)
            $display("** x86_16bit_instruction_decoder_unit: PASSED **");
        else
            $display("** x86_16bit_instruction_decoder_unit: FAILED **");
        $finish;
    end
endmodule
